FILE: src/battery_capacity_rate_limit_filter_unit_macros.svh
// Assertion shorthands for the filter unit.
`ifndef BATTERY_CAPACITY_RATE_LIMIT_FILTER_UNIT_MACROS_SVH
`define BATTERY_CAPACITY_RATE_LIMIT_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked on clock, off during reset.
`define BCRLF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on clock, off during reset.
`define BCRLF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/bcrlf_pkg.sv
package bcrlf_pkg;

   localparam int PCT_W     = 7;
   localparam int CUR_W     = 12;
   localparam int IVAL_W    = 16;
   localparam int CAP_W     = 13;
   localparam int SCALE_W   = 14;
   localparam int SCALED_W  = CUR_W + SCALE_W;
   localparam int DIV_W     = SCALED_W + IVAL_W;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int SLOT_W    = 23;
   localparam int CARRY_W   = 5;
   localparam int EXCESS_W  = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0]    CAP_RESET      = 13'd2100;
   localparam logic [CAP_W-1:0]    HOUR_S         = 13'd3600;
   localparam logic [CAP_W-1:0]    TENTH_DIV      = 13'd10;
   localparam logic [CAP_W-1:0]    PCT_DIV        = 13'd100;
   localparam logic [SCALE_W-1:0]  SCALE_CHARGE   = 14'd100;
   localparam logic [SCALE_W-1:0]  SCALE_TENTH    = 14'd1000;
   localparam logic [SCALE_W-1:0]  SCALE_DRAIN    = 14'd10000;
   localparam logic [CUR_W-1:0]    SUSPEND_MA     = 12'd10;
   localparam logic [CUR_W-1:0]    FAST_LOW_MA    = 12'd1400;
   localparam logic [CUR_W-1:0]    FAST_HIGH_MA   = 12'd900;
   localparam logic [CUR_W-1:0]    CALL_MA        = 12'd200;
   localparam logic [CUR_W-1:0]    IDLE_MA        = 12'd30;
   localparam logic [PCT_W-1:0]    LOW_LEVEL      = 7'd10;
   localparam logic [PCT_W-1:0]    SHUTDOWN_LAST  = 7'd3;
   localparam logic [PCT_W-1:0]    NEAR_FULL_PCT  = 7'd83;
   localparam logic [PCT_W-1:0]    BEFORE_FULL_PCT = 7'd99;
   localparam logic [PCT_W-1:0]    FULL_PCT       = 7'd100;
   localparam logic [CARRY_W-1:0]  CARRY_BASE     = 5'd10;
   localparam logic [EXCESS_W-1:0] EXCESS_MAX     = 2'd3;
   localparam logic [EXCESS_W-1:0] EXCESS_FAST    = 2'd2;
   localparam logic                CSR_IDX_CAP    = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DCAP_GO,
      ST_DCAP_WAIT,
      ST_MUL,
      ST_DHOUR_GO,
      ST_DHOUR_WAIT,
      ST_DPOST_GO,
      ST_DPOST_WAIT,
      ST_STORE,
      ST_FINISH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      DIV_CAP,
      DIV_HOUR,
      DIV_POST
   } div_src_type;

   typedef struct packed {
      logic        capture;
      logic        div_start;
      div_src_type div_src;
      logic        mul_load;
      logic        store;
      logic        pass;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic shutdown;
      logic cable;
      logic trivial;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

FILE: src/bcrlf_div.sv
module bcrlf_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bcrlf_pkg::DIV_W-1:0]  dividend,
   input  logic [bcrlf_pkg::CAP_W-1:0]  divisor,
   output logic                         busy,
   output logic [bcrlf_pkg::DIV_W-1:0]  quotient,
   output logic [bcrlf_pkg::CAP_W-1:0]  remainder
);
   import bcrlf_pkg::*;

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [CAP_W-1:0]     rem_ff, rem_in;
   logic [CAP_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [DIV_W-1:0]     quo_step;
   logic [CAP_W-1:0]     rem_step;

   // two restoring steps per cycle
   always_comb begin
      logic [CAP_W:0] t;
      logic [CAP_W:0] d;
      logic           ge;
      quo_step = quo_ff;
      rem_step = rem_ff;
      t  = '0;
      ge = 1'b0;
      d  = {1'b0, dvs_ff};
      for (int i = 0; i < 2; i++) begin
         t  = {rem_step, quo_step[DIV_W-1]};
         ge = (t >= d);
         if (ge) begin
            t = t - d;
         end
         rem_step = t[CAP_W-1:0];
         quo_step = {quo_step[DIV_W-2:0], ge};
      end
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: src/bcrlf_dp.sv
module bcrlf_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  bcrlf_pkg::cmd_type            cmd,
   output bcrlf_pkg::status_type         status,
   input  logic [bcrlf_pkg::CAP_W-1:0]   cap_eff,
   input  logic [bcrlf_pkg::PCT_W-1:0]   req_raw_percent,
   input  logic [bcrlf_pkg::PCT_W-1:0]   req_last_percent,
   input  logic                          req_cable_present,
   input  logic                          req_charging_now,
   input  logic                          req_battery_full,
   input  logic                          req_battery_low,
   input  logic [bcrlf_pkg::CUR_W-1:0]   req_max_current_ma,
   input  logic [bcrlf_pkg::IVAL_W-1:0]  req_interval_seconds,
   input  logic                          req_in_call,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bcrlf_pkg::PCT_W-1:0]   rsp_filtered_percent
);
   import bcrlf_pkg::*;

   logic [PCT_W-1:0]    now_ff, last_ff;
   logic                cable_ff, charging_ff, full_ff, low_ff, call_ff;
   logic [CUR_W-1:0]    cur_ff;
   logic [IVAL_W-1:0]   ival_ff;
   logic [DIV_W-1:0]    prod_ff;
   logic [SLOT_W-1:0]   slot0_ff, slot1_ff, slot_in;
   logic [EXCESS_W-1:0] excess_ff, exc_nx;
   logic [CARRY_W-1:0]  carry_ff, carry_nx;
   logic                hold_ff, hold_nx;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0]    pct_ff, pct_nx;

   logic                rise_pos, drop_pos, ival_zero, shutdown, out_free, commit;
   logic [CUR_W-1:0]    fast_cur, cval;
   logic [SCALE_W-1:0]  scale;
   logic [SCALED_W-1:0] scaled;
   logic [DIV_W-1:0]    dividend, quo;
   logic [CAP_W-1:0]    divisor, rem;
   logic                div_busy;

   bcrlf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .busy      (div_busy),
      .quotient  (quo),
      .remainder (rem)
   );

   assign rise_pos  = now_ff > last_ff;
   assign drop_pos  = last_ff > now_ff;
   assign ival_zero = ival_ff == '0;
   assign shutdown  = low_ff && (now_ff == '0) && (last_ff <= SHUTDOWN_LAST);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = cmd.finish && out_free;

   assign status.shutdown = shutdown;
   assign status.cable    = cable_ff;
   assign status.trivial  = ival_zero || (cable_ff ? !rise_pos : !drop_pos);
   assign status.div_busy = div_busy;
   assign status.out_free = out_free;

   always_comb begin
      if (cur_ff == SUSPEND_MA) begin
         fast_cur = call_ff ? CALL_MA : IDLE_MA;
      end else begin
         fast_cur = (now_ff < LOW_LEVEL) ? FAST_LOW_MA : FAST_HIGH_MA;
      end
      cval = (cmd.pass && !cable_ff) ? fast_cur : cur_ff;
      if (cable_ff) begin
         scale = cmd.pass ? SCALE_TENTH : SCALE_CHARGE;
      end else begin
         scale = SCALE_DRAIN;
      end
   end

   assign scaled = SCALED_W'(cval) * SCALED_W'(scale);

   always_comb begin
      case (cmd.div_src)
         DIV_CAP: begin
            dividend = DIV_W'(scaled);
            divisor  = cap_eff;
         end
         DIV_HOUR: begin
            dividend = prod_ff;
            divisor  = HOUR_S;
         end
         DIV_POST: begin
            dividend = quo;
            divisor  = cable_ff ? TENTH_DIV : PCT_DIV;
         end
         default: begin
            dividend = '0;
            divisor  = '0;
         end
      endcase
   end

   assign slot_in = (cable_ff && cmd.pass) ? SLOT_W'(rem) : quo[SLOT_W-1:0];

   always_comb begin
      logic [PCT_W-1:0]   rise, drop, life;
      logic [CARRY_W-1:0] carry_sum;
      logic               carry_wrap;
      logic [SLOT_W:0]    lim_c;
      logic [SLOT_W-1:0]  lim_d;
      logic               use_fast;
      rise       = now_ff - last_ff;
      drop       = last_ff - now_ff;
      carry_sum  = carry_ff + slot1_ff[CARRY_W-1:0];
      carry_wrap = carry_sum >= CARRY_BASE;
      lim_c      = {1'b0, slot0_ff} + (SLOT_W + 1)'(carry_wrap);
      exc_nx     = excess_ff;
      carry_nx   = carry_ff;
      hold_nx    = hold_ff;
      life       = last_ff;
      use_fast   = 1'b0;
      lim_d      = slot0_ff;
      if (cable_ff) begin
         if (rise_pos && !ival_zero) begin
            carry_nx = carry_wrap ? carry_sum - CARRY_BASE : carry_sum;
            if (lim_c < (SLOT_W + 1)'(rise)) begin
               life = last_ff + lim_c[PCT_W-1:0];
            end else begin
               life = now_ff;
            end
         end else if (rise_pos) begin
            life = now_ff;
         end
      end else begin
         if (!drop_pos) begin
            if (excess_ff != '0) begin
               exc_nx = excess_ff - 1'b1;
            end
         end else if (!ival_zero) begin
            if (SLOT_W'(drop) > slot0_ff) begin
               if (excess_ff != EXCESS_MAX) begin
                  exc_nx = excess_ff + 1'b1;
               end
            end else if (excess_ff != '0) begin
               exc_nx = excess_ff - 1'b1;
            end
            use_fast = ((exc_nx >= EXCESS_FAST) && (now_ff < LOW_LEVEL))
                       || (exc_nx == EXCESS_MAX);
            lim_d = use_fast ? slot1_ff : slot0_ff;
            if (lim_d < SLOT_W'(drop)) begin
               life = last_ff - lim_d[PCT_W-1:0];
            end else begin
               life = now_ff;
            end
         end
      end
      // one-shot hold against a drop while charging
      if ((life < last_ff) && charging_ff && !hold_ff) begin
         life    = last_ff;
         hold_nx = 1'b1;
      end
      if ((life > last_ff) && hold_ff) begin
         hold_nx = 1'b0;
      end
      if (!low_ff && (life == '0)) begin
         life = PCT_W'(1);
      end else if (life >= FULL_PCT) begin
         life = full_ff ? FULL_PCT : BEFORE_FULL_PCT;
      end else if ((life >= NEAR_FULL_PCT) && cable_ff && full_ff) begin
         life = FULL_PCT;
      end
      pct_nx = shutdown ? '0 : life;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         excess_ff    <= '0;
         carry_ff     <= '0;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (commit && !shutdown) begin
            excess_ff <= exc_nx;
            carry_ff  <= carry_nx;
            hold_ff   <= hold_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff      <= req_raw_percent;
         last_ff     <= req_last_percent;
         cable_ff    <= req_cable_present;
         charging_ff <= req_charging_now;
         full_ff     <= req_battery_full;
         low_ff      <= req_battery_low;
         cur_ff      <= req_max_current_ma;
         ival_ff     <= req_interval_seconds;
         call_ff     <= req_in_call;
      end
      if (cmd.mul_load) begin
         prod_ff <= DIV_W'(quo[SCALED_W-1:0]) * DIV_W'(ival_ff);
      end
      if (cmd.store && !cmd.pass) begin
         slot0_ff <= slot_in;
      end
      if (cmd.store && cmd.pass) begin
         slot1_ff <= slot_in;
      end
      if (commit) begin
         pct_ff <= pct_nx;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_filtered_percent = pct_ff;

endmodule

FILE: src/bcrlf_ctrl.sv
module bcrlf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bcrlf_pkg::status_type status,
   output bcrlf_pkg::cmd_type    cmd
);
   import bcrlf_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           pass_ff, pass_in;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            pass_in = 1'b0;
            if (status.shutdown || status.trivial) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DCAP_GO;
            end
         end
         ST_DCAP_GO:  state_in = ST_DCAP_WAIT;
         ST_DCAP_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:      state_in = ST_DHOUR_GO;
         ST_DHOUR_GO: state_in = ST_DHOUR_WAIT;
         ST_DHOUR_WAIT: begin
            if (!status.div_busy) begin
               state_in = (status.cable && !pass_ff) ? ST_STORE : ST_DPOST_GO;
            end
         end
         ST_DPOST_GO: state_in = ST_DPOST_WAIT;
         ST_DPOST_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (pass_ff) begin
               state_in = ST_FINISH;
            end else begin
               pass_in  = 1'b1;
               state_in = ST_DCAP_GO;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.div_src = DIV_CAP;
      cmd.pass    = pass_ff;
      req_stall   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_DCAP_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_CAP;
         end
         ST_MUL:      cmd.mul_load = 1'b1;
         ST_DHOUR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_HOUR;
         end
         ST_DPOST_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_POST;
         end
         ST_STORE:    cmd.store  = 1'b1;
         ST_FINISH:   cmd.finish = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

FILE: src/battery_capacity_rate_limit_filter_unit.sv
// Battery capacity rate-limit filter. One beat in, one beat out: each sample
// yields a filtered percentage, 0 on shutdown. Samples are handled one at a
// time. A shutdown sample, a zero interval or a level that does not rise on
// cable or drop on battery goes from the check straight to the result; a rise
// on cable or a drop on battery runs through the single shared divider (two
// quotient bits a cycle) that does the divisions by capacity, by 3600 and by
// 100 or 10 in turn. A new sample is taken the cycle after the result is
// loaded into the output register. Capacity at register addresses 0 to 3
// resets to 2100 mAh; a value of 0 acts as 1.
`include "battery_capacity_rate_limit_filter_unit_macros.svh"

module battery_capacity_rate_limit_filter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bcrlf_pkg::PCT_W-1:0]       req_raw_percent,
   input  logic [bcrlf_pkg::PCT_W-1:0]       req_last_percent,
   input  logic                              req_cable_present,
   input  logic                              req_charging_now,
   input  logic                              req_battery_full,
   input  logic                              req_battery_low,
   input  logic [bcrlf_pkg::CUR_W-1:0]       req_max_current_ma,
   input  logic [bcrlf_pkg::IVAL_W-1:0]      req_interval_seconds,
   input  logic                              req_in_call,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bcrlf_pkg::PCT_W-1:0]       rsp_filtered_percent,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bcrlf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bcrlf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bcrlf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import bcrlf_pkg::*;

   logic [CAP_W-1:0] cap_ff, cap_in, cap_eff;
   logic             csr_write;
   cmd_type          dp_cmd;
   status_type       dp_status;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cap_in     = (csr_write && (csr_paddr[2] == CSR_IDX_CAP))
                       ? csr_pwdata[CAP_W-1:0] : cap_ff;
   assign cap_eff    = (cap_ff == '0) ? CAP_W'(1) : cap_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_CAP) ? CSR_DATA_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   bcrlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   bcrlf_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (dp_cmd),
      .status               (dp_status),
      .cap_eff              (cap_eff),
      .req_raw_percent      (req_raw_percent),
      .req_last_percent     (req_last_percent),
      .req_cable_present    (req_cable_present),
      .req_charging_now     (req_charging_now),
      .req_battery_full     (req_battery_full),
      .req_battery_low      (req_battery_low),
      .req_max_current_ma   (req_max_current_ma),
      .req_interval_seconds (req_interval_seconds),
      .req_in_call          (req_in_call),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_filtered_percent (rsp_filtered_percent)
   );

   `BCRLF_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "beat taken while busy")
   `BCRLF_ASSERT_SAME(a_div_busy_stalls, dp_status.div_busy, req_stall, "divider runs while idle")
   `BCRLF_ASSERT_NEXT(a_cap_write, csr_write && (csr_paddr[2] == CSR_IDX_CAP), cap_ff == $past(csr_pwdata[CAP_W-1:0]), "capacity write lost")
   `BCRLF_ASSERT_SAME(a_pct_range, rsp_valid, rsp_filtered_percent <= FULL_PCT, "result above full")

endmodule
